// ===== rtl/core/hsc_pkg.sv =====
// Package with shared types, constants and helper functions of the hostname syntax checker.
package hsc_pkg;

  localparam int DEF_MAX_NAME_LEN = 255;
  localparam int MAX_LABEL_LEN    = 63;

  localparam int LABEL_LEN_W = 7;
  localparam logic [LABEL_LEN_W-1:0] LABEL_LEN_SAT = 7'd127;
  localparam logic [7:0] POS_SAT = 8'd255;

  localparam logic [7:0] CHAR_DOT    = 8'h2E;
  localparam logic [7:0] CHAR_HYPHEN = 8'h2D;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_EDGE    = 3'd1,
    ST_LONG    = 3'd2,
    ST_LABEL   = 3'd3,
    ST_ILLEGAL = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    KIND_NONE    = 2'd0,
    KIND_LABEL   = 2'd1,
    KIND_ILLEGAL = 2'd2
  } err_kind_t;

  typedef struct packed {
    logic       fire;
    status_t    status;
    logic [7:0] error_position;
  } verdict_t;

  function automatic logic legal_byte(input logic [7:0] c);
    return (c inside {[8'h61:8'h7A], [8'h30:8'h39], [8'h41:8'h5A], CHAR_DOT, CHAR_HYPHEN});
  endfunction

  function automatic logic edge_byte(input logic [7:0] c);
    return (c == CHAR_DOT) || (c == CHAR_HYPHEN);
  endfunction

endpackage

// ===== rtl/core/hsc_in_if.sv =====
// Input channel interface carrying one hostname byte per item.
interface hsc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       is_last;
  logic       is_empty;

  modport source (output valid, output char_byte, output is_last, output is_empty,
                  input ready);
  modport sink (input valid, input char_byte, input is_last, input is_empty,
                output ready);
endinterface

// ===== rtl/core/hsc_out_if.sv =====
// Result channel interface carrying one verdict per item.
interface hsc_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [7:0] error_position;

  modport source (output valid, output status, output error_position, input ready);
  modport sink (input valid, input status, input error_position, output ready);
endinterface

// ===== rtl/core/hsc_step.sv =====
// Next-state and verdict logic for one hostname byte.
module hsc_step #(
  parameter int MAX_NAME_LEN = hsc_pkg::DEF_MAX_NAME_LEN,
  parameter int BC_W         = $clog2(MAX_NAME_LEN + 2)
) (
  input  logic [7:0]                     char_byte,
  input  logic                           is_last,
  input  logic                           is_empty,
  input  logic [BC_W-1:0]                byte_count,
  input  logic [hsc_pkg::LABEL_LEN_W-1:0] label_length,
  input  logic [7:0]                     previous_byte,
  input  logic                           first_byte_bad,
  input  hsc_pkg::err_kind_t             pending_kind,
  input  logic [7:0]                     pending_index,
  output logic [BC_W-1:0]                byte_count_nxt,
  output logic [hsc_pkg::LABEL_LEN_W-1:0] label_length_nxt,
  output logic [7:0]                     previous_byte_nxt,
  output logic                           first_byte_bad_nxt,
  output hsc_pkg::err_kind_t             pending_kind_nxt,
  output logic [7:0]                     pending_index_nxt,
  output hsc_pkg::verdict_t              verdict
);

  localparam int POS_W = (BC_W + 1 > 9) ? BC_W + 1 : 9;
  localparam logic [BC_W-1:0]  COUNT_SAT = BC_W'(MAX_NAME_LEN + 1);
  localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(255);

  logic [POS_W-1:0] pos;
  logic [BC_W-1:0] count_upd;
  logic            is_dot;
  logic [hsc_pkg::LABEL_LEN_W-1:0] label_upd;
  hsc_pkg::err_kind_t kind_upd;
  logic [7:0]      index_upd;
  logic            first_upd;

  assign pos    = POS_W'(byte_count) + POS_W'(1);
  assign is_dot = (char_byte == hsc_pkg::CHAR_DOT);

  always_comb begin
    kind_upd  = pending_kind;
    index_upd = pending_index;
    if (pending_kind == hsc_pkg::KIND_NONE) begin
      if (!hsc_pkg::legal_byte(char_byte)) begin
        kind_upd  = hsc_pkg::KIND_ILLEGAL;
        index_upd = (pos > POS_LIMIT) ? hsc_pkg::POS_SAT : pos[7:0];
      end else if (is_dot) begin
        if ((byte_count != '0) && (previous_byte == hsc_pkg::CHAR_DOT)) begin
          kind_upd = hsc_pkg::KIND_LABEL;
        end
      end else if (label_length >= hsc_pkg::LABEL_LEN_W'(hsc_pkg::MAX_LABEL_LEN)) begin
        kind_upd = hsc_pkg::KIND_LABEL;
      end
    end
    if (is_dot) begin
      label_upd = '0;
    end else if (label_length < hsc_pkg::LABEL_LEN_SAT) begin
      label_upd = label_length + hsc_pkg::LABEL_LEN_W'(1);
    end else begin
      label_upd = label_length;
    end
    first_upd = first_byte_bad || ((byte_count == '0) && hsc_pkg::edge_byte(char_byte));
    count_upd = (byte_count < COUNT_SAT) ? byte_count + BC_W'(1) : byte_count;
  end

  always_comb begin
    verdict.fire           = is_empty || is_last;
    verdict.status         = hsc_pkg::ST_OK;
    verdict.error_position = '0;
    if (is_empty || first_upd || hsc_pkg::edge_byte(char_byte)) begin
      verdict.status = hsc_pkg::ST_EDGE;
    end else if (count_upd > BC_W'(MAX_NAME_LEN)) begin
      verdict.status = hsc_pkg::ST_LONG;
    end else if (kind_upd == hsc_pkg::KIND_ILLEGAL) begin
      verdict.status         = hsc_pkg::ST_ILLEGAL;
      verdict.error_position = index_upd;
    end else if (kind_upd == hsc_pkg::KIND_LABEL) begin
      verdict.status = hsc_pkg::ST_LABEL;
    end
  end

  always_comb begin
    if (is_empty || is_last) begin
      byte_count_nxt     = '0;
      label_length_nxt   = '0;
      previous_byte_nxt  = '0;
      first_byte_bad_nxt = 1'b0;
      pending_kind_nxt   = hsc_pkg::KIND_NONE;
      pending_index_nxt  = '0;
    end else begin
      byte_count_nxt     = count_upd;
      label_length_nxt   = label_upd;
      previous_byte_nxt  = char_byte;
      first_byte_bad_nxt = first_upd;
      pending_kind_nxt   = kind_upd;
      pending_index_nxt  = index_upd;
    end
  end

endmodule

// ===== rtl/core/hostname_syntax_checker.sv =====
// Top level of the hostname syntax checker with input register, scan state and result register.
//
//   channel  | dir | payload                          | accepted when
//   in_ch    | in  | char_byte, is_last, is_empty     | valid && ready
//   out_ch   | out | status, error_position           | valid && ready
//
// One byte is taken per cycle unless a stalled result holds it; the state update sets the rate.
// A verdict enters the result register when its last (or empty) item leaves the input register.
// Reset clears the scan state and both valid flags.
// A stalled result holds the pipeline; the input register still accepts one item meanwhile.
module hostname_syntax_checker #(
  parameter int MAX_NAME_LEN = hsc_pkg::DEF_MAX_NAME_LEN
) (
  input logic      clk,
  input logic      rst_n,
  hsc_in_if.sink   in_ch,
  hsc_out_if.source out_ch
);

  localparam int BC_W = $clog2(MAX_NAME_LEN + 2);

  logic       in_valid_r;
  logic [7:0] in_char_r;
  logic       in_last_r;
  logic       in_empty_r;
  logic       advance;

  logic [BC_W-1:0]                 byte_count_r, byte_count_nxt;
  logic [hsc_pkg::LABEL_LEN_W-1:0] label_length_r, label_length_nxt;
  logic [7:0]                      previous_byte_r, previous_byte_nxt;
  logic                            first_byte_bad_r, first_byte_bad_nxt;
  hsc_pkg::err_kind_t              pending_kind_r, pending_kind_nxt;
  logic [7:0]                      pending_index_r, pending_index_nxt;
  hsc_pkg::verdict_t               verdict;

  logic            out_valid_r;
  hsc_pkg::status_t out_status_r;
  logic [7:0]      out_pos_r;

  assign advance     = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_char_r  <= in_ch.char_byte;
      in_last_r  <= in_ch.is_last;
      in_empty_r <= in_ch.is_empty;
    end
  end

  hsc_step #(
    .MAX_NAME_LEN(MAX_NAME_LEN),
    .BC_W        (BC_W)
  ) u_step (
    .char_byte         (in_char_r),
    .is_last           (in_last_r),
    .is_empty          (in_empty_r),
    .byte_count        (byte_count_r),
    .label_length      (label_length_r),
    .previous_byte     (previous_byte_r),
    .first_byte_bad    (first_byte_bad_r),
    .pending_kind      (pending_kind_r),
    .pending_index     (pending_index_r),
    .byte_count_nxt    (byte_count_nxt),
    .label_length_nxt  (label_length_nxt),
    .previous_byte_nxt (previous_byte_nxt),
    .first_byte_bad_nxt(first_byte_bad_nxt),
    .pending_kind_nxt  (pending_kind_nxt),
    .pending_index_nxt (pending_index_nxt),
    .verdict           (verdict)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r     <= '0;
      label_length_r   <= '0;
      previous_byte_r  <= '0;
      first_byte_bad_r <= 1'b0;
      pending_kind_r   <= hsc_pkg::KIND_NONE;
      pending_index_r  <= '0;
    end else if (advance) begin
      byte_count_r     <= byte_count_nxt;
      label_length_r   <= label_length_nxt;
      previous_byte_r  <= previous_byte_nxt;
      first_byte_bad_r <= first_byte_bad_nxt;
      pending_kind_r   <= pending_kind_nxt;
      pending_index_r  <= pending_index_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= verdict.fire;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && verdict.fire) begin
      out_status_r <= verdict.status;
      out_pos_r    <= verdict.error_position;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_status_r;
  assign out_ch.error_position = out_pos_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r != hsc_pkg::ST_ILLEGAL) |-> (out_pos_r == 8'd0))
    else $error("error position set on a verdict that is not an illegal byte");

  assert property (@(posedge clk) disable iff (!rst_n)
    advance && in_empty_r |=> out_valid_r && (out_status_r == hsc_pkg::ST_EDGE))
    else $error("empty name did not give an edge verdict");

  assert property (@(posedge clk) disable iff (!rst_n)
    advance && verdict.fire |=> (byte_count_r == '0) && (pending_kind_r == hsc_pkg::KIND_NONE))
    else $error("scan state not cleared after a verdict");

  assert property (@(posedge clk) disable iff (!rst_n)
    byte_count_r <= BC_W'(MAX_NAME_LEN + 1))
    else $error("byte count passed its saturation value");

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the hostname syntax checker, with its own verdict predictor.
module testbench;

  localparam int NAME_LIMIT  = hsc_pkg::DEF_MAX_NAME_LEN;
  localparam int LABEL_LIMIT = hsc_pkg::MAX_LABEL_LEN;
  localparam int RANDOM_BYTES = 160;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    hsc_pkg::status_t status;
    logic [7:0]       position;
  } expected_verdict_t;

  logic clk = 1'b0;
  logic rst_n;

  hsc_in_if  in_ch ();
  hsc_out_if out_ch ();

  hostname_syntax_checker DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Scan state of the predictor.
  logic [8:0]         seen_bytes;
  logic [6:0]         label_bytes;
  logic [7:0]         last_byte;
  logic               leading_edge;
  hsc_pkg::err_kind_t first_error;
  logic [7:0]         first_error_pos;

  expected_verdict_t expected_verdicts[$];
  expected_verdict_t oldest_verdict;
  logic [7:0]        name_buf[$];

  int failures = 0;
  int bytes_sent = 0;
  int names_sent = 0;
  int verdicts_checked = 0;
  int cycles = 0;
  bit idle_en = 1'b1;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d, expected %0d (verdict %0d)", what, got, want,
             verdicts_checked);
    failures++;
  endtask

  function automatic logic is_host_char(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h30 && c <= 8'h39) ||
           (c >= 8'h41 && c <= 8'h5A) || c == hsc_pkg::CHAR_DOT ||
           c == hsc_pkg::CHAR_HYPHEN;
  endfunction

  function automatic logic is_edge_char(input logic [7:0] c);
    return c == hsc_pkg::CHAR_DOT || c == hsc_pkg::CHAR_HYPHEN;
  endfunction

  task automatic clear_scan();
    seen_bytes      = '0;
    label_bytes     = '0;
    last_byte       = '0;
    leading_edge    = 1'b0;
    first_error     = hsc_pkg::KIND_NONE;
    first_error_pos = '0;
  endtask

  task automatic scan_byte(input logic [7:0] c, input logic last, input logic empty);
    logic [9:0]        pos;
    expected_verdict_t v;
    v.status   = hsc_pkg::ST_OK;
    v.position = '0;
    if (empty) begin
      v.status = hsc_pkg::ST_EDGE;
      expected_verdicts.push_back(v);
      clear_scan();
    end else begin
      pos = seen_bytes + 10'd1;
      if (first_error == hsc_pkg::KIND_NONE) begin
        if (!is_host_char(c)) begin
          first_error     = hsc_pkg::KIND_ILLEGAL;
          first_error_pos = (pos > 10'd255) ? hsc_pkg::POS_SAT : pos[7:0];
        end else if (c == hsc_pkg::CHAR_DOT) begin
          if (seen_bytes != 0 && last_byte == hsc_pkg::CHAR_DOT) first_error = hsc_pkg::KIND_LABEL;
        end else if (label_bytes >= LABEL_LIMIT) begin
          first_error = hsc_pkg::KIND_LABEL;
        end
      end
      if (c == hsc_pkg::CHAR_DOT) label_bytes = '0;
      else if (label_bytes < hsc_pkg::LABEL_LEN_SAT) label_bytes = label_bytes + 7'd1;
      if (seen_bytes == 0 && is_edge_char(c)) leading_edge = 1'b1;
      last_byte = c;
      if (seen_bytes < NAME_LIMIT + 1) seen_bytes = seen_bytes + 9'd1;
      if (last) begin
        if (leading_edge || is_edge_char(c)) begin
          v.status = hsc_pkg::ST_EDGE;
        end else if (seen_bytes > NAME_LIMIT) begin
          v.status = hsc_pkg::ST_LONG;
        end else if (first_error == hsc_pkg::KIND_ILLEGAL) begin
          v.status   = hsc_pkg::ST_ILLEGAL;
          v.position = first_error_pos;
        end else if (first_error == hsc_pkg::KIND_LABEL) begin
          v.status = hsc_pkg::ST_LABEL;
        end
        expected_verdicts.push_back(v);
        clear_scan();
      end
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_en || r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 25);
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance with valid held.
  task automatic send_item(input logic [7:0] c, input logic last, input logic empty);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid     = 1'b1;
    in_ch.char_byte = c;
    in_ch.is_last   = last;
    in_ch.is_empty  = empty;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    scan_byte(c, last, empty);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_name();
    for (int i = 0; i < name_buf.size(); i++) begin
      send_item(name_buf[i], i == name_buf.size() - 1, 1'b0);
    end
    name_buf.delete();
    names_sent++;
  endtask

  task automatic send_empty();
    send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
    names_sent++;
  endtask

  task automatic drain_verdicts();
    in_ch.valid = 1'b0;
    while (expected_verdicts.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) name_buf.push_back(s[i]);
  endtask

  task automatic add_run(input logic [7:0] c, input int n);
    repeat (n) name_buf.push_back(c);
  endtask

  function automatic logic [7:0] rand_alnum();
    int r;
    r = $urandom_range(0, 61);
    if (r < 26) return 8'(8'h61 + r);
    if (r < 52) return 8'(8'h41 + (r - 26));
    return 8'(8'h30 + (r - 52));
  endfunction

  task automatic add_label(input int len);
    for (int i = 0; i < len; i++) begin
      if (i == 0 || i == len - 1 || $urandom_range(0, 9) != 0) name_buf.push_back(rand_alnum());
      else name_buf.push_back(hsc_pkg::CHAR_HYPHEN);
    end
  endtask

  // Appends a well-formed run of labels of exactly n bytes.
  task automatic add_long(input int n);
    int start;
    start = name_buf.size();
    while (name_buf.size() - start < n) begin
      if (name_buf.size() != start) name_buf.push_back(hsc_pkg::CHAR_DOT);
      add_label($urandom_range(1, 50));
    end
    while (name_buf.size() - start > n) void'(name_buf.pop_back());
    if (is_edge_char(name_buf[name_buf.size() - 1])) name_buf[name_buf.size() - 1] = 8'h61;
  endtask

  task automatic test_legal_names();
    add_text("a");                   send_name();
    add_text("az09AZ");              send_name();
    add_text("a.b-c.d");             send_name();
    add_text("Zz9-0.y-Y");           send_name();
  endtask

  task automatic test_edge_chars();
    add_text("-abc");                send_name();
    add_text("abc-");                send_name();
    add_text(".abc");                send_name();
    add_text("abc.");                send_name();
    add_text("-");                   send_name();
    add_text(".");                   send_name();
  endtask

  task automatic test_empty_names();
    send_empty();
    send_item(8'h61, 1'b0, 1'b0);
    send_item(8'h5F, 1'b0, 1'b0);
    send_item(8'hFF, 1'b1, 1'b1);
    names_sent++;
    add_text("b");                   send_name();
  endtask

  task automatic test_label_rules();
    add_text("a..b");                send_name();
    add_text("x.");                  add_run(8'h63, LABEL_LIMIT + 1); send_name();
    add_text("a..b_");               send_name();
  endtask

  task automatic test_illegal_bytes();
    add_text("ab_c");                send_name();
    name_buf.push_back(8'h00);       add_text("a"); send_name();
    add_text("a");                   name_buf.push_back(8'hFF); send_name();
    add_text("a/:@[`{b");            send_name();
    add_text("a_..b");               send_name();
    add_run(8'h61, LABEL_LIMIT);     name_buf.push_back(8'h5F); send_name();
  endtask

  task automatic test_name_length();
    add_run(8'h61, LABEL_LIMIT);     name_buf.push_back(hsc_pkg::CHAR_DOT);
    add_long(NAME_LIMIT - LABEL_LIMIT - 1); send_name();
    add_long(NAME_LIMIT);            name_buf.push_back(8'h21); send_name();
  endtask

  task automatic random_name();
    int r;
    int pos;
    r = $urandom_range(0, 99);
    if (r < 3) begin
      add_long($urandom_range(16, 64));
      send_name();
    end else if (r < 13) begin
      repeat ($urandom_range(1, 12)) name_buf.push_back(8'($urandom_range(0, 255)));
      send_name();
    end else if (r < 17) begin
      send_empty();
    end else if (r < 21) begin
      repeat ($urandom_range(1, 6)) send_item(rand_alnum(), 1'b0, 1'b0);
      send_empty();
    end else begin
      repeat ($urandom_range(1, 4)) begin
        if (name_buf.size() != 0) name_buf.push_back(hsc_pkg::CHAR_DOT);
        if ($urandom_range(0, 19) == 0) add_label($urandom_range(LABEL_LIMIT - 3, LABEL_LIMIT + 3));
        else add_label($urandom_range(1, 8));
      end
      if ($urandom_range(0, 3) == 0) begin
        pos = $urandom_range(0, name_buf.size() - 1);
        case ($urandom_range(0, 3))
          0: name_buf[pos] = 8'($urandom_range(0, 255));
          1: name_buf.insert(pos, hsc_pkg::CHAR_DOT);
          2: begin
            if ($urandom_range(0, 1))
              name_buf.push_front($urandom_range(0, 1) ? hsc_pkg::CHAR_DOT : hsc_pkg::CHAR_HYPHEN);
            else
              name_buf.push_back($urandom_range(0, 1) ? hsc_pkg::CHAR_DOT : hsc_pkg::CHAR_HYPHEN);
          end
          default: begin
            case ($urandom_range(0, 7))
              0: name_buf[pos] = 8'h2F;
              1: name_buf[pos] = 8'h3A;
              2: name_buf[pos] = 8'h40;
              3: name_buf[pos] = 8'h5B;
              4: name_buf[pos] = 8'h60;
              5: name_buf[pos] = 8'h7B;
              6: name_buf[pos] = 8'h00;
              default: name_buf[pos] = 8'hFF;
            endcase
          end
        endcase
      end
      send_name();
    end
  endtask

  task automatic test_random_names();
    int start;
    int phase;
    start = bytes_sent;
    phase = 0;
    while (bytes_sent - start < RANDOM_BYTES) begin
      idle_en = (phase % 3) != 2;
      repeat (4) random_name();
      if (phase == 1) drain_verdicts();
      phase++;
    end
    idle_en = 1'b1;
  endtask

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!idle_en || $urandom_range(0, 99) < 70) begin
        out_ch.ready = 1'b1;
      end else begin
        out_ch.ready = 1'b0;
        repeat ($urandom_range(0, 9) < 8 ? $urandom_range(0, 2) : $urandom_range(8, 30))
          @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_verdicts.size() == 0) begin
        report_mismatch("unexpected verdict, status", out_ch.status, -1);
      end else begin
        oldest_verdict = expected_verdicts.pop_front();
        if (out_ch.status !== oldest_verdict.status)
          report_mismatch("status", out_ch.status, oldest_verdict.status);
        if (out_ch.error_position !== oldest_verdict.position)
          report_mismatch("error_position", out_ch.error_position, oldest_verdict.position);
        verdicts_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d verdicts outstanding", cycles,
               expected_verdicts.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.char_byte = '0;
    in_ch.is_last   = 1'b0;
    in_ch.is_empty  = 1'b0;
    clear_scan();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_legal_names();
    test_edge_chars();
    test_empty_names();
    test_label_rules();
    test_illegal_bytes();
    test_name_length();
    test_random_names();

    drain_verdicts();
    repeat (10) @(negedge clk);

    $display("Sent %0d names in %0d bytes: legal names, edge, empty, label, illegal and",
             names_sent, bytes_sent);
    $display("length cases plus random names; %0d verdicts checked", verdicts_checked);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/hsc_pkg.sv
rtl/core/hsc_in_if.sv
rtl/core/hsc_out_if.sv
rtl/core/hsc_step.sv
rtl/core/hostname_syntax_checker.sv
verif/testbench.sv
